// ===== design/gtm_pkg.sv =====
// ----------------------------------------------------------------------------
// gtm_pkg
// Shared widths, register indexes, reset values and sequencer states for the
// Goertzel tone magnitude detector.
// ----------------------------------------------------------------------------
package gtm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEFF_W     = 16;
    localparam int MAG_W       = 24;
    localparam int ACC_W       = 32;
    localparam int COUNT_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int WINDOW_LEN_DEF = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_TWO_COS_IDX = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIN_IDX     = 2'd1;

    localparam logic signed [COEFF_W-1:0] TWO_COS_RESET = 16'sd23170;
    localparam logic signed [COEFF_W-1:0] SIN_RESET     = 16'sd23170;

    localparam logic [MAG_W-1:0] MAG_MAX = 24'hFFFFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REC_MUL,
        ST_REC_ADD,
        ST_RE_MUL,
        ST_RE_ADD,
        ST_IM_MUL,
        ST_IM_ADD,
        ST_ABS,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_SUM,
        ST_ROOT,
        ST_OUT
    } gtm_state_t;

endpackage

// ===== design/goertzel_tone_magnitude.sv =====
// ----------------------------------------------------------------------------
// goertzel_tone_magnitude
// Goertzel recurrence over a window of audio samples with a shared multiplier,
// then a digit-by-digit square root of the tone power at window end.
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// s_       in         s_valid/s_ready    s_sample      (signed 16)
// m_       out        m_valid/m_ready    m_magnitude   (unsigned 24)
// cfg_     in         cfg_wr_en          cfg_index, cfg_wdata (16)
//
// A sample that does not close the window is captured, multiplied, then added
// and saturated. The closing sample goes on to the real and imaginary parts,
// their magnitudes (an oversize part saturates the result at once), the
// squares and their sum, the square root (one result bit per cycle) and the
// output register load, which waits while the previous result is held. Reset
// is synchronous, active low, and clears recurrence, count and output valid.
// ----------------------------------------------------------------------------
module goertzel_tone_magnitude #(
    parameter int unsigned WINDOW_LEN = gtm_pkg::WINDOW_LEN_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [gtm_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gtm_pkg::MAG_W-1:0]           m_magnitude,
    input  logic                                cfg_wr_en,
    input  logic [gtm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gtm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import gtm_pkg::*;

    localparam int PROD_W = 58;
    localparam int WIDE_W = 59;
    localparam int PART_W = 34;
    localparam int SQ_W   = 48;
    localparam int N_W    = 49;
    localparam int ROOT_W = 50;

    gtm_state_t state_reg, state_next;

    logic signed [COEFF_W-1:0]  two_cos_reg, sin_reg;
    logic signed [ACC_W-1:0]    q1_reg, q1_next;
    logic signed [ACC_W-1:0]    q2_reg, q2_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PART_W-1:0]   re_reg, re_next;
    logic signed [PART_W-1:0]   im_reg, im_next;
    logic [MAG_W-1:0]           are_reg, are_next;
    logic [MAG_W-1:0]           aim_reg, aim_next;
    logic [SQ_W-1:0]            sq_reg, sq_next;
    logic [N_W-1:0]             n_reg, n_next;
    logic [ROOT_W-1:0]          root_reg, root_next;
    logic [N_W-1:0]             bit_reg, bit_next;
    logic [MAG_W-1:0]           mag_reg, mag_next;
    logic                       m_valid_reg, m_valid_next;
    logic [MAG_W-1:0]           m_mag_reg, m_mag_next;

    logic signed [32:0]         mul_a;
    logic signed [24:0]         mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [PROD_W-1:0]   rnd14, rnd15;
    logic signed [WIDE_W-1:0]   q0_wide, re_wide;
    logic signed [ACC_W-1:0]    q0_sat;
    logic [PART_W-1:0]          re_abs, im_abs;
    logic [ROOT_W-1:0]          trial;
    logic [COUNT_W:0]           count_inc;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_magnitude = m_mag_reg;

    assign mul_p = mul_a * mul_b;
    assign rnd14 = (prod_reg + 58'sd8192) >>> 14;
    assign rnd15 = (prod_reg + 58'sd16384) >>> 15;

    assign q0_wide = WIDE_W'(rnd14) - WIDE_W'(q2_reg) + WIDE_W'(x_reg);
    assign re_wide = WIDE_W'(q1_reg) - WIDE_W'(rnd15);

    always_comb begin
        if (q0_wide > 59'sd2147483647) begin
            q0_sat = 32'sh7FFFFFFF;
        end else if (q0_wide < -59'sd2147483648) begin
            q0_sat = 32'sh80000000;
        end else begin
            q0_sat = q0_wide[ACC_W-1:0];
        end
    end

    assign re_abs    = re_reg[PART_W-1] ? PART_W'(-re_reg) : PART_W'(re_reg);
    assign im_abs    = im_reg[PART_W-1] ? PART_W'(-im_reg) : PART_W'(im_reg);
    assign trial     = root_reg + {1'b0, bit_reg};
    assign count_inc = {1'b0, count_reg} + 9'd1;

    always_comb begin
        state_next   = state_reg;
        q1_next      = q1_reg;
        q2_next      = q2_reg;
        count_next   = count_reg;
        x_next       = x_reg;
        re_next      = re_reg;
        im_next      = im_reg;
        are_next     = are_reg;
        aim_next     = aim_reg;
        sq_next      = sq_reg;
        n_next       = n_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        mag_next     = mag_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_mag_next   = m_mag_reg;
        mul_a        = 33'(q1_reg);
        mul_b        = 25'(two_cos_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x_next     = s_sample;
                    state_next = ST_REC_MUL;
                end
            end
            ST_REC_MUL: begin
                state_next = ST_REC_ADD;
            end
            ST_REC_ADD: begin
                q2_next = q1_reg;
                q1_next = q0_sat;
                if (count_inc < (COUNT_W+1)'(WINDOW_LEN)) begin
                    count_next = count_inc[COUNT_W-1:0];
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_RE_MUL;
                end
            end
            ST_RE_MUL: begin
                mul_a      = 33'(q2_reg);
                state_next = ST_RE_ADD;
            end
            ST_RE_ADD: begin
                re_next    = re_wide[PART_W-1:0];
                state_next = ST_IM_MUL;
            end
            ST_IM_MUL: begin
                mul_a      = 33'(q2_reg);
                mul_b      = 25'(sin_reg);
                state_next = ST_IM_ADD;
            end
            ST_IM_ADD: begin
                im_next    = rnd15[PART_W-1:0];
                state_next = ST_ABS;
            end
            ST_ABS: begin
                are_next = re_abs[MAG_W-1:0];
                aim_next = im_abs[MAG_W-1:0];
                if (re_abs > PART_W'(MAG_MAX) || im_abs > PART_W'(MAG_MAX)) begin
                    mag_next   = MAG_MAX;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SQ_RE;
                end
            end
            ST_SQ_RE: begin
                mul_a      = signed'({9'd0, are_reg});
                mul_b      = signed'({1'b0, are_reg});
                state_next = ST_SQ_IM;
            end
            ST_SQ_IM: begin
                sq_next    = prod_reg[SQ_W-1:0];
                mul_a      = signed'({9'd0, aim_reg});
                mul_b      = signed'({1'b0, aim_reg});
                state_next = ST_SUM;
            end
            ST_SUM: begin
                n_next     = {1'b0, sq_reg} + {1'b0, prod_reg[SQ_W-1:0]};
                root_next  = '0;
                bit_next   = {1'b1, {(N_W-1){1'b0}}};
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if ({1'b0, n_reg} >= trial) begin
                    n_next    = N_W'({1'b0, n_reg} - trial);
                    root_next = (root_reg >> 1) + {1'b0, bit_reg};
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_next == '0) begin
                    if (root_next > ROOT_W'(MAG_MAX)) begin
                        mag_next = MAG_MAX;
                    end else begin
                        mag_next = root_next[MAG_W-1:0];
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_mag_next   = mag_reg;
                    q1_next      = '0;
                    q2_next      = '0;
                    count_next   = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q1_reg      <= '0;
            q2_reg      <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            two_cos_reg <= TWO_COS_RESET;
            sin_reg     <= SIN_RESET;
        end else begin
            q1_reg      <= q1_next;
            q2_reg      <= q2_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en && cfg_index == CFG_TWO_COS_IDX) begin
                two_cos_reg <= signed'(cfg_wdata[COEFF_W-1:0]);
            end
            if (cfg_wr_en && cfg_index == CFG_SIN_IDX) begin
                sin_reg <= signed'(cfg_wdata[COEFF_W-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        prod_reg  <= mul_p;
        re_reg    <= re_next;
        im_reg    <= im_next;
        are_reg   <= are_next;
        aim_reg   <= aim_next;
        sq_reg    <= sq_next;
        n_reg     <= n_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        mag_reg   <= mag_next;
        m_mag_reg <= m_mag_next;
    end

endmodule
